/* src/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and round functions for the AES-128 cipher core.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int KeyRows   = NumRounds + 1;
   localparam int RowAddrW  = $clog2(KeyRows);

   // configuration register indexes
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef logic [7:0] byte_tbl_type [256];

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_KEY,
      ST_IDLE,
      ST_ARK,
      ST_ROUND,
      ST_DONE
   } aes_state_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
   } rsp_type;

   // multiply by x modulo x^8+x^4+x^3+x+1
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // general field multiply, used only to build the tables
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h01;
      // a^254 by repeated multiplication
      for (int i = 0; i < 254; i++) r = gf_mul(r, a);
      return r;
   endfunction

   function automatic byte_tbl_type make_sbox();
      byte_tbl_type t;
      logic [7:0]   b;
      for (int i = 0; i < 256; i++) begin
         b    = gf_inv(8'(i));
         t[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
              ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
      return t;
   endfunction

   localparam byte_tbl_type SBOX = make_sbox();

   function automatic byte_tbl_type make_inv_sbox();
      byte_tbl_type t;
      for (int i = 0; i < 256; i++) t[SBOX[i]] = 8'(i);
      return t;
   endfunction

   localparam byte_tbl_type INV_SBOX = make_inv_sbox();

   // byte n of a block sits at bits [127-8n -: 8]; n = 4*column + row
   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int n = 0; n < 16; n++)
         r[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
      return r;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int row = 0; row < 4; row++)
         for (int c = 0; c < 4; c++) begin
            if (inv)
               r[127-8*(4*c+row) -: 8] = s[127-8*(4*((c+4-row)%4)+row) -: 8];
            else
               r[127-8*(4*c+row) -: 8] = s[127-8*(4*((c+row)%4)+row) -: 8];
         end
      return r;
   endfunction

   function automatic logic [31:0] mix_column(input logic [31:0] w, input logic inv);
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] c2 [4];
      logic [7:0] c3 [4];
      logic [7:0] c9 [4];
      logic [7:0] cb [4];
      logic [7:0] cd [4];
      logic [7:0] ce [4];
      logic [31:0] r;
      for (int k = 0; k < 4; k++) begin
         a[k]  = w[31-8*k -: 8];
         m2[k] = xtime(a[k]);
         m4[k] = xtime(m2[k]);
         m8[k] = xtime(m4[k]);
         c2[k] = m2[k];
         c3[k] = m2[k] ^ a[k];
         c9[k] = m8[k] ^ a[k];
         cb[k] = m8[k] ^ m2[k] ^ a[k];
         cd[k] = m8[k] ^ m4[k] ^ a[k];
         ce[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      for (int row = 0; row < 4; row++) begin
         if (inv)
            r[31-8*row -: 8] = ce[row] ^ cb[(row+1)%4] ^ cd[(row+2)%4] ^ c9[(row+3)%4];
         else
            r[31-8*row -: 8] = c2[row] ^ c3[(row+1)%4] ^ a[(row+2)%4] ^ a[(row+3)%4];
      end
      return r;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int c = 0; c < 4; c++) r[127-32*c -: 32] = mix_column(s[127-32*c -: 32], inv);
      return r;
   endfunction

   // next round-key row from the previous one
   function automatic logic [127:0] next_key_row(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]}
         ^ {rcon, 24'h000000};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

/* src/aes128_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// AES-128 block cipher top
// Round-iterative AES-128 encrypt/decrypt core, round keys held in a RAM.
// ----------------------------------------------------------------------------
// Each block runs the key add, ten rounds and the load of the output register from
// input transfer to result valid; one round per cycle, set by the single round-key
// RAM read port. A new block is taken only after the previous result is loaded.
// Reset and every key write run a key expansion of eleven rows into the RAM, one
// row per cycle; input is stalled until it finishes.
module aes128_block_cipher_top
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   aes_state_type state_ff, state_in;
   logic [63:0]   key_high_ff, key_low_ff;
   logic [RowAddrW-1:0] row_ff, row_in;
   logic [3:0]    round_ff, round_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic [127:0]  kx_ff, kx_in;
   logic [127:0]  work_ff, work_in;
   logic          cmd_ff, cmd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;
   logic          rsp_load;

   logic [127:0]  rk_mem [KeyRows];
   logic [127:0]  rk_q;
   logic [RowAddrW-1:0] rd_addr;
   logic          rk_we;

   logic          req_xfer, rsp_xfer, csr_xfer;
   logic [127:0]  round_out, t_enc, t_dec;
   logic          last_round;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_xfer) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // round datapath
   assign last_round = (round_ff == 4'(NumRounds));
   always_comb begin
      t_enc = shift_rows(sub_bytes(work_ff, 1'b0), 1'b0);
      if (!last_round) t_enc = mix_columns(t_enc, 1'b0);
      t_enc = t_enc ^ rk_q;
      t_dec = sub_bytes(shift_rows(work_ff, 1'b1), 1'b1) ^ rk_q;
      if (!last_round) t_dec = mix_columns(t_dec, 1'b1);
      round_out = (cmd_ff == CMD_DECRYPT) ? t_dec : t_enc;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      round_in     = round_ff;
      rcon_in      = rcon_ff;
      kx_in        = kx_ff;
      work_in      = work_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_load     = 1'b0;
      rk_we        = 1'b0;
      rd_addr      = '0;
      // hold input while a key write is offered so the new key applies first
      req_stall    = (state_ff != ST_IDLE) || csr_valid;

      case (state_ff)
         ST_KEY: begin
            rk_we = 1'b1;
            if (row_ff == '0) begin
               kx_in   = {key_high_ff, key_low_ff};
               rcon_in = 8'h01;
            end else begin
               kx_in   = next_key_row(kx_ff, rcon_ff);
               rcon_in = xtime(rcon_ff);
            end
            row_in = row_ff + RowAddrW'(1);
            if (row_ff == RowAddrW'(NumRounds)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            rd_addr = req_payload.cmd ? RowAddrW'(NumRounds) : '0;
            if (req_xfer) begin
               work_in  = {req_payload.block_high, req_payload.block_low};
               cmd_in   = req_payload.cmd;
               round_in = '0;
               state_in = ST_ARK;
            end
         end
         ST_ARK: begin
            work_in  = work_ff ^ rk_q;
            round_in = 4'd1;
            rd_addr  = (cmd_ff == CMD_DECRYPT) ? RowAddrW'(NumRounds - 1) : RowAddrW'(1);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in  = round_out;
            round_in = round_ff + 4'd1;
            if (cmd_ff == CMD_DECRYPT)
               rd_addr = RowAddrW'(NumRounds - 1) - RowAddrW'(round_ff);
            else
               rd_addr = RowAddrW'(round_ff) + RowAddrW'(1);
            if (last_round) begin
               round_in = round_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a key write restarts the expansion
      if (csr_xfer) begin
         state_in = ST_KEY;
         row_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEY;
         row_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rcon_ff <= rcon_in;
      kx_ff   <= kx_in;
      work_ff <= work_in;
      cmd_ff  <= cmd_in;
      if (rsp_load) rsp_data_ff <= {work_ff[127:64], work_ff[63:0]};
   end

   // round-key RAM, registered read
   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[row_ff] <= kx_in;
      rk_q <= rk_mem[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // checks
   a_accept_to_ark: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !csr_xfer |=> state_ff == ST_ARK)
      else $error("accepted block did not start key add");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff >= 4'd1 && round_ff <= 4'(NumRounds))
      else $error("round counter out of range");
   a_key_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KEY |-> req_stall)
      else $error("input taken during key expansion");
   a_done_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall) && !csr_xfer |=> rsp_valid_ff)
      else $error("result not presented");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Feeds directed and random blocks, encrypt and decrypt, under several keys and
// idle profiles; an independent AES model predicts each result for checking.
// ----------------------------------------------------------------------------
module testbench
   import aes_pkg::*;
();

   localparam int   CYCLE_LIMIT  = 600000;
   localparam int   DRAIN_CYCLES = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [63:0] csr_data = '0;

   aes128_block_cipher_top DUT (.*);

   // testbench copy of the key and the lookup tables
   logic [127:0] cipher_key = '0;
   logic [7:0]   fwd_sub [256];
   logic [7:0]   rev_sub [256];

   req_type      pending_blocks [$];
   rsp_type      expected_blocks [$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   bit           hold_input = 1'b0;
   int           error_count = 0;
   int           cycle_count = 0;

   function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotb(logic [7:0] b, int n);
      return (b << n) | (b >> (8 - n));
   endfunction

   // build both substitution tables: brute-force inverse, then the affine map
   initial begin
      logic [7:0] inv_val;
      logic [7:0] s;
      for (int a = 0; a < 256; a++) begin
         inv_val = 8'h00;
         for (int b = 1; b < 256; b++)
            if (field_mul(8'(a), 8'(b)) == 8'h01) inv_val = 8'(b);
         s = inv_val ^ rotb(inv_val, 1) ^ rotb(inv_val, 2) ^ rotb(inv_val, 3)
           ^ rotb(inv_val, 4) ^ 8'h63;
         fwd_sub[a] = s;
         rev_sub[s] = 8'(a);
      end
   end

   // full cipher on a column-major state: byte n = 4*column + row
   function automatic logic [127:0] aes_transform(logic decrypt, logic [127:0] blk,
                                                 logic [127:0] key);
      logic [31:0] kw [44];
      logic [31:0] t;
      logic [7:0]  rc;
      logic [7:0]  st [16];
      logic [7:0]  tmp [16];
      logic [7:0]  mat [4];
      logic [127:0] res;
      int          rnd;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) kw[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = kw[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]}
              ^ {rc, 24'h0};
            rc = field_mul(rc, 8'h02);
         end
         kw[i] = kw[i-4] ^ t;
      end
      for (int n = 0; n < 16; n++) st[n] = blk[127-8*n -: 8];
      for (int step = 0; step <= 10; step++) begin
         rnd = decrypt ? 10 - step : step;
         if (step > 0) begin
            // substitute and shift rows
            tmp = st;
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  st[4*c+r] = decrypt ? rev_sub[tmp[4*((c+4-r)%4)+r]]
                                      : fwd_sub[tmp[4*((c+r)%4)+r]];
            // forward mixing precedes the key add
            if (!decrypt && step != 10) begin
               mat = '{8'h02, 8'h03, 8'h01, 8'h01};
               tmp = st;
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++) begin
                     st[4*c+r] = 8'h00;
                     for (int k = 0; k < 4; k++)
                        st[4*c+r] ^= field_mul(mat[(k+4-r)%4], tmp[4*c+k]);
                  end
            end
         end
         for (int n = 0; n < 16; n++) st[n] ^= kw[4*rnd + n/4][31-8*(n%4) -: 8];
         // inverse mixing follows the key add
         if (decrypt && step > 0 && step != 10) begin
            mat = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            tmp = st;
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  st[4*c+r] = 8'h00;
                  for (int k = 0; k < 4; k++)
                     st[4*c+r] ^= field_mul(mat[(k+4-r)%4], tmp[4*c+k]);
               end
         end
      end
      for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // clock and cycle limit
   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // driver: predict on each transfer, then offer the next block
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_blocks.push_back(aes_transform(req_payload.cmd,
               {req_payload.block_high, req_payload.block_low}, cipher_key));
         if (!req_valid || !req_stall) begin
            if (!hold_input && pending_blocks.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_blocks.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer, stall at random
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result", rsp_payload.out_high, '0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_payload.out_high !== want.out_high)
                  report_mismatch("out_high", rsp_payload.out_high, want.out_high);
               if (rsp_payload.out_low !== want.out_low)
                  report_mismatch("out_low", rsp_payload.out_low, want.out_low);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_reg(logic idx, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_KEY_HIGH) cipher_key[127:64] = value;
      else cipher_key[63:0] = value;
   endtask

   task automatic load_key(logic [127:0] key);
      write_reg(CSR_KEY_HIGH, key[127:64]);
      write_reg(CSR_KEY_LOW, key[63:0]);
   endtask

   task automatic queue_block(cmd_type op, logic [127:0] blk);
      req_type item;
      item.cmd        = op;
      item.block_high = blk[127:64];
      item.block_low  = blk[63:0];
      pending_blocks.push_back(item);
   endtask

   function automatic logic [127:0] rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // wait until every block has gone through and the core is quiet
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_blocks.size() > 0 || req_valid || expected_blocks.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         queue_block(cmd_type'($urandom_range(1)), rand_block());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset key, then extremes and the standard test vector
      send_idle_pct = 32;
      recv_idle_pct = 80;
      @(negedge clock);
      queue_block(CMD_ENCRYPT, '0);
      queue_block(CMD_DECRYPT, '0);
      queue_block(CMD_ENCRYPT, '1);
      wait_drained();
      load_key(128'h000102030405060708090a0b0c0d0e0f);
      @(negedge clock);
      queue_block(CMD_ENCRYPT, 128'h00112233445566778899aabbccddeeff);
      queue_block(CMD_DECRYPT, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
      queue_block(CMD_ENCRYPT, 128'haaaaaaaaaaaaaaaa5555555555555555);
      queue_block(CMD_DECRYPT, '1);
      wait_drained();
      load_key('1);
      @(negedge clock);
      queue_block(CMD_ENCRYPT, '0);
      queue_block(CMD_ENCRYPT, '1);
      queue_block(CMD_DECRYPT, '0);
      queue_block(CMD_DECRYPT, '1);
      wait_drained();
      // change only the low half; the high half stays all ones
      write_reg(CSR_KEY_LOW, 64'h0);
      @(negedge clock);
      queue_block(CMD_ENCRYPT, 128'h0123456789abcdeffedcba9876543210);
      queue_block(CMD_DECRYPT, 128'h0123456789abcdeffedcba9876543210);
      wait_drained();

      // random, first profile, with a pause midway until all results are back
      load_key(rand_block());
      @(negedge clock);
      queue_random(150);
      do @(posedge clock); while (pending_blocks.size() > 75);
      @(negedge clock);
      hold_input = 1'b1;
      do @(posedge clock); while (req_valid || expected_blocks.size() > 0);
      @(negedge clock);
      hold_input = 1'b0;
      queue_random(150);
      wait_drained();

      // swap the idle profiles
      send_idle_pct = 80;
      recv_idle_pct = 32;
      load_key(rand_block());
      @(negedge clock);
      queue_random(300);
      wait_drained();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_key(rand_block());
      @(negedge clock);
      queue_random(300);
      wait_drained();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* aes128_block_cipher_top.f */
src/aes_pkg.sv
src/aes128_block_cipher_top.sv
test/testbench.sv
